@@ sv/lrc_pkg.sv @@
// shared constants and types for the lru result cache
package lrc_pkg;

  localparam int LRC_CAPACITY = 16;
  localparam int KEY_W        = 64;
  localparam int LEVEL_W      = 2;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  // update control broadcast from the sequencer to every cell
  typedef struct packed {
    logic go;
    logic insert;
    logic any_match;
    logic full;
  } upd_ctl_t;

endpackage

@@ sv/lrc_cell.sv @@
// one cache entry: tag, level, valid mark and recency rank
module lrc_cell
  import lrc_pkg::*;
#(
  parameter int CAPACITY = LRC_CAPACITY
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  look_en,
  input  upd_ctl_t                              ctl,
  input  logic [$clog2(CAPACITY+1)-1:0]         old_rank,
  input  logic [KEY_W-1:0]                      key,
  input  logic [LEVEL_W-1:0]                    level,
  input  logic                                  free_in,
  output logic                                  free_out,
  output logic                                  match_o,
  output logic                                  valid_o,
  output logic [$clog2(CAPACITY)-1:0]           rank_o,
  output logic [LEVEL_W-1:0]                    level_o
);

  localparam int RANK_W = $clog2(CAPACITY);
  localparam int OLD_W  = $clog2(CAPACITY + 1);

  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [RANK_W-1:0]  rank_r, rank_nxt;
  logic               valid_r, valid_nxt;
  logic               match_r;

  logic match_now;
  logic claim;
  logic oldest;
  logic target;
  logic move;

  assign match_now = valid_r && (key_r == key);
  assign claim     = !valid_r && !free_in;
  assign free_out  = free_in || !valid_r;
  assign oldest    = valid_r && (rank_r == RANK_W'(CAPACITY - 1));

  // a hit targets the matching entry, a new key the free or the oldest one
  assign target = ctl.any_match ? match_r : (ctl.insert && (ctl.full ? oldest : claim));
  assign move   = ctl.go && (ctl.any_match || ctl.insert);

  assign match_o = match_now;
  assign valid_o = valid_r;
  assign rank_o  = match_now ? rank_r : '0;
  assign level_o = match_now ? level_r : '0;

  always_comb begin
    rank_nxt  = rank_r;
    valid_nxt = valid_r;
    key_nxt   = key_r;
    level_nxt = level_r;
    if (move) begin
      if (target) begin
        rank_nxt = '0;
        if (ctl.insert) begin
          level_nxt = level;
          if (!ctl.any_match) begin
            key_nxt   = key;
            valid_nxt = 1'b1;
          end
        end
      end else if (valid_r && (OLD_W'(rank_r) < old_rank)) begin
        rank_nxt = rank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (look_en) begin
        match_r <= match_now;
      end
    end
    key_r   <= key_nxt;
    level_r <= level_nxt;
    rank_r  <= rank_nxt;
  end

endmodule

@@ sv/lru_result_cache_core.sv @@
// top level of the lru result cache: sequencer, cell row and result register
//
// Fully associative least-recently-used cache of CAPACITY entries mapping a
// 64-bit key to a two-bit level. An input item (in_action, in_key,
// in_new_level) is a lookup or an insert; each item yields exactly one
// result item (out_hit, out_found_level, out_evicted).
// Both channels use valid/stall: an item moves on a rising edge where valid
// is high and stall is low.
// Each item goes through accept, a compare cycle in which every cell checks
// its tag, and an update cycle in which every cell adjusts its rank and the
// target cell is written. The result is registered at the end of the update
// cycle. A new item is accepted only after the previous one has finished its
// update cycle.
// The next item may be accepted while a result waits on a stalled output.
// If the output is still stalled when the next update is due, that update
// waits until the result register frees up; in_stall stays high meanwhile.
// Reset (rst_n low, synchronous) clears all valid marks; the cache is empty
// and ready right after reset.
module lru_result_cache_core
  import lrc_pkg::*;
#(
  parameter int CAPACITY = LRC_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [LEVEL_W-1:0] in_new_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [LEVEL_W-1:0] out_found_level,
  output logic               out_evicted
);

  localparam int RANK_W = $clog2(CAPACITY);
  localparam int OLD_W  = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_UPD} state_t;

  state_t             state_r, state_nxt;
  logic               action_r;
  logic [KEY_W-1:0]   key_r;
  logic [LEVEL_W-1:0] level_r;
  logic               any_match_r;
  logic               full_r;
  logic [RANK_W-1:0]  hit_rank_r;
  logic [LEVEL_W-1:0] hit_level_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r;
  logic [LEVEL_W-1:0] out_found_level_r;
  logic               out_evicted_r;

  logic                  in_take;
  logic                  out_free;
  logic                  upd_go;
  upd_ctl_t              ctl;
  logic [OLD_W-1:0]      old_rank;
  logic [CAPACITY:0]     free_chain;
  logic [CAPACITY-1:0]   cell_match;
  logic [CAPACITY-1:0]   cell_valid;
  logic [RANK_W-1:0]     cell_rank  [CAPACITY];
  logic [LEVEL_W-1:0]    cell_level [CAPACITY];
  logic [RANK_W-1:0]     red_rank;
  logic [LEVEL_W-1:0]    red_level;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign upd_go   = (state_r == ST_UPD) && out_free;

  assign ctl.go        = upd_go;
  assign ctl.insert    = (action_r == ACT_INSERT);
  assign ctl.any_match = any_match_r;
  assign ctl.full      = full_r;

  // rank the target held before; a fresh slot ages every valid entry
  assign old_rank = any_match_r ? OLD_W'(hit_rank_r) :
                    (full_r ? OLD_W'(CAPACITY - 1) : OLD_W'(CAPACITY));

  assign free_chain[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lrc_cell #(
      .CAPACITY (CAPACITY)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .look_en  (state_r == ST_LOOK),
      .ctl      (ctl),
      .old_rank (old_rank),
      .key      (key_r),
      .level    (level_r),
      .free_in  (free_chain[i]),
      .free_out (free_chain[i+1]),
      .match_o  (cell_match[i]),
      .valid_o  (cell_valid[i]),
      .rank_o   (cell_rank[i]),
      .level_o  (cell_level[i])
    );
  end

  // at most one entry matches, so an or of the masked fields picks it
  always_comb begin
    red_rank  = '0;
    red_level = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      red_rank  = red_rank | cell_rank[i];
      red_level = red_level | cell_level[i];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (upd_go) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_take) begin
      action_r <= in_action;
      key_r    <= in_key;
      level_r  <= in_new_level;
    end
    if (state_r == ST_LOOK) begin
      any_match_r <= |cell_match;
      full_r      <= &cell_valid;
      hit_rank_r  <= red_rank;
      hit_level_r <= red_level;
    end
    if (upd_go) begin
      out_hit_r         <= any_match_r;
      out_found_level_r <= (action_r == ACT_LOOKUP && any_match_r) ? hit_level_r : '0;
      out_evicted_r     <= (action_r == ACT_INSERT) && !any_match_r && full_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_found_level = out_found_level_r;
  assign out_evicted     = out_evicted_r;

endmodule
